@@ sv/mpl2d_pkg.sv @@
// ---------------------------------------------------------------------------
// mpl2d_pkg
// Types and constants shared by the masked patch L2 distance block.
// ---------------------------------------------------------------------------
`default_nettype none

package mpl2d_pkg;

   localparam int unsigned PIXEL_BITS = 8;
   localparam int unsigned SUM_BITS   = 28;
   localparam int unsigned SQ_BITS    = 2 * PIXEL_BITS;
   localparam int unsigned FRAC_BITS  = 8;
   localparam int unsigned ROOT_BITS  = 22;
   localparam int unsigned OPND_BITS  = 2 * ROOT_BITS;
   localparam int unsigned REM_BITS   = ROOT_BITS + 1;
   localparam int unsigned STEP_BITS  = 5;

   localparam logic [SUM_BITS-1:0]  SUM_MAX   = '1;
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(ROOT_BITS - 1);

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MASK_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EMPTY_CODE  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_CODE = 2'd2;
   localparam int unsigned CSR_DATA_BITS = 8;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_a;
      logic [PIXEL_BITS-1:0] pixel_b;
      logic [PIXEL_BITS-1:0] pixel_status;
      logic                  last_pixel;
   } req_type;

   typedef struct packed {
      logic [ROOT_BITS-1:0] distance_q8;
      logic                 saturated;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_ROOT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic accept;
      logic root_load;
      logic root_step;
   } cmd_type;

   typedef struct packed {
      logic last_at_acc;
   } status_type;

endpackage : mpl2d_pkg

`default_nettype wire

@@ sv/mpl2d_ctrl.sv @@
// ---------------------------------------------------------------------------
// mpl2d_ctrl
// Controller: accepts requests, waits for the last pixel to reach the
// accumulator, then sequences the square root steps and the reply.
// ---------------------------------------------------------------------------
`default_nettype none

module mpl2d_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  last_pixel,
   output logic                       busy,
   output logic                       rsp_strobe,
   output mpl2d_pkg::cmd_type         cmd,
   input  wire mpl2d_pkg::status_type status
);
   import mpl2d_pkg::*;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && last_pixel) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.last_at_acc) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (step_ff == LAST_STEP) state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      rsp_strobe     = 1'b0;
      step_in        = step_ff;
      cmd.accept     = accept;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_DRAIN: begin
            cmd.root_load = status.last_at_acc;
            step_in       = '0;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + 1'b1;
         end
         ST_REPLY: begin
            rsp_strobe = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule : mpl2d_ctrl

`default_nettype wire

@@ sv/mpl2d_dp.sv @@
// ---------------------------------------------------------------------------
// mpl2d_dp
// Datapath: configuration registers, two-stage square pipeline, saturating
// accumulator and a radix-2 restoring square root unit.
// ---------------------------------------------------------------------------
`default_nettype none

module mpl2d_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [mpl2d_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mpl2d_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire mpl2d_pkg::req_type                     req_data,
   input  wire mpl2d_pkg::cmd_type                     cmd,
   output mpl2d_pkg::status_type                       status,
   output mpl2d_pkg::rsp_type                          rsp_data
);
   import mpl2d_pkg::*;

   // Configuration.
   logic                   mask_enable_ff;
   logic [PIXEL_BITS-1:0]  empty_code_ff;
   logic [PIXEL_BITS-1:0]  target_code_ff;

   // Stage 1: registered request.
   logic                   s1_valid_ff;
   logic                   s1_keep_ff;
   logic                   s1_last_ff;
   logic [PIXEL_BITS-1:0]  s1_a_ff;
   logic [PIXEL_BITS-1:0]  s1_b_ff;

   // Stage 2: squared difference.
   logic                   s2_valid_ff;
   logic                   s2_keep_ff;
   logic                   s2_last_ff;
   logic [SQ_BITS-1:0]     s2_sq_ff, s2_sq_in;

   // Accumulator.
   logic [SUM_BITS-1:0]    acc_ff, acc_in;
   logic                   sat_ff, sat_in;
   logic [SUM_BITS:0]      acc_wide;
   logic [SUM_BITS-1:0]    sum_next;
   logic                   sat_next;

   // Square root unit.
   logic [OPND_BITS-1:0]   opnd_ff, opnd_in;
   logic [REM_BITS-1:0]    rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic                   rsp_sat_ff, rsp_sat_in;
   logic [REM_BITS+1:0]    rem_shift;
   logic [REM_BITS+1:0]    trial;
   logic [REM_BITS+1:0]    rem_diff;

   logic                   req_skip;
   logic [PIXEL_BITS-1:0]  abs_diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_enable_ff <= 1'b1;
         empty_code_ff  <= 8'd0;
         target_code_ff <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MASK_ENABLE: mask_enable_ff <= csr_wdata[0];
            CSR_EMPTY_CODE:  empty_code_ff  <= csr_wdata;
            CSR_TARGET_CODE: target_code_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_skip = mask_enable_ff &&
                     ((req_data.pixel_status == empty_code_ff) ||
                      (req_data.pixel_status == target_code_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         s1_keep_ff <= ~req_skip;
         s1_last_ff <= req_data.last_pixel;
         s1_a_ff    <= req_data.pixel_a;
         s1_b_ff    <= req_data.pixel_b;
      end
   end

   assign abs_diff = (s1_a_ff > s1_b_ff) ? (s1_a_ff - s1_b_ff) : (s1_b_ff - s1_a_ff);
   assign s2_sq_in = SQ_BITS'(abs_diff) * SQ_BITS'(abs_diff);

   always_ff @(posedge clock) begin
      s2_keep_ff <= s1_keep_ff;
      s2_last_ff <= s1_last_ff;
      s2_sq_ff   <= s2_sq_in;
   end

   assign status.last_at_acc = s2_valid_ff & s2_last_ff;

   // The sum clamps at its maximum; reaching the maximum exactly also counts
   // as saturation.
   always_comb begin
      acc_wide = {1'b0, acc_ff} + (SUM_BITS+1)'(s2_sq_ff);
      sum_next = acc_ff;
      sat_next = sat_ff;
      if (s2_keep_ff) begin
         if (acc_wide >= {1'b0, SUM_MAX}) begin
            sum_next = SUM_MAX;
            sat_next = 1'b1;
         end else begin
            sum_next = acc_wide[SUM_BITS-1:0];
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (cmd.root_load) begin
         acc_in = '0;
         sat_in = 1'b0;
      end else if (s2_valid_ff) begin
         acc_in = sum_next;
         sat_in = sat_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         sat_ff <= sat_in;
      end
   end

   // Each step brings down two operand bits and decides one root bit.
   assign rem_shift = {rem_ff, opnd_ff[OPND_BITS-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign rem_diff  = rem_shift - trial;

   always_comb begin
      opnd_in    = opnd_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      rsp_sat_in = rsp_sat_ff;
      if (cmd.root_load) begin
         opnd_in    = {sum_next, {(OPND_BITS-SUM_BITS){1'b0}}};
         rem_in     = '0;
         root_in    = '0;
         rsp_sat_in = sat_next;
      end else if (cmd.root_step) begin
         opnd_in = {opnd_ff[OPND_BITS-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_diff[REM_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[REM_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff    <= opnd_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_data.distance_q8 = root_ff;
   assign rsp_data.saturated   = rsp_sat_ff;

endmodule : mpl2d_dp

`default_nettype wire

@@ sv/masked_patch_l2_distance.sv @@
// ---------------------------------------------------------------------------
// masked_patch_l2_distance
// Masked sum of squared pixel differences over a patch, reported as the
// square root in unsigned fixed point with 8 fraction bits.
// ---------------------------------------------------------------------------
// Pixels are taken one per cycle while busy is low. A request that carries
// last_pixel raises busy: the final square passes through the two pipeline
// registers, and when it reaches the accumulator the root unit is loaded
// with the final sum; the root unit then retires one result bit per cycle,
// and the result is shown on rsp_data for the single cycle that rsp_strobe
// is high. The receiver cannot stall, so it must take the result in that
// cycle. The accumulator is cleared with each result.
`default_nettype none

module masked_patch_l2_distance (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire mpl2d_pkg::req_type                   req_data,
   output logic                                      rsp_strobe,
   output mpl2d_pkg::rsp_type                        rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [mpl2d_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mpl2d_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mpl2d_pkg::*;

   cmd_type    cmd;
   status_type status;

   mpl2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_pixel (req_data.last_pixel),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   mpl2d_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule : masked_patch_l2_distance

`default_nettype wire

@@ tb/sv/masked_patch_l2_distance_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// masked_patch_l2_distance_tb
// Streams directed and random patches into the masked L2 distance block and
// checks each reported distance and saturation flag against a local model
// of the masked sum of squares and its fixed-point square root.
// ---------------------------------------------------------------------------

module masked_patch_l2_distance_tb;
   import mpl2d_pkg::*;

   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned SETTLE_TICKS = 30;

   // Tracks the block's accumulator and the distances it must report.
   class distance_scoreboard;
      bit                  mask_on;
      logic [7:0]          empty_val;
      logic [7:0]          target_val;
      logic [SUM_BITS-1:0] sum_sq;
      bit                  sum_sat;
      rsp_type             distance_q[$];
      int                  errors;

      function new();
         mask_on    = 1'b1;
         empty_val  = 8'd0;
         target_val = 8'd1;
         sum_sq     = '0;
         sum_sat    = 1'b0;
         errors     = 0;
      endfunction

      function void set_codes(bit mask_bit, logic [7:0] empty_code, logic [7:0] target_code);
         mask_on    = mask_bit;
         empty_val  = empty_code;
         target_val = target_code;
      endfunction

      function int pending();
         return distance_q.size();
      endfunction

      // Floor of the square root of sum * 2^16, one root bit at a time.
      function logic [ROOT_BITS-1:0] root_q8(logic [SUM_BITS-1:0] total);
         logic [43:0]          radicand;
         logic [ROOT_BITS-1:0] root;
         logic [ROOT_BITS-1:0] trial;
         logic [43:0]          trial_sq;
         radicand = {total, 16'h0000};
         root = '0;
         for (int i = ROOT_BITS - 1; i >= 0; i--) begin
            trial    = root | (22'd1 << i);
            trial_sq = trial * trial;
            if (trial_sq <= radicand) root = trial;
         end
         return root;
      endfunction

      function void add_pixel(req_type px);
         logic [7:0]  diff;
         logic [15:0] square;
         logic [28:0] total;
         rsp_type     result;
         bit          masked;
         masked = mask_on && (px.pixel_status == empty_val ||
                              px.pixel_status == target_val);
         if (!masked) begin
            diff   = (px.pixel_a > px.pixel_b) ? px.pixel_a - px.pixel_b
                                               : px.pixel_b - px.pixel_a;
            square = diff * diff;
            total  = sum_sq + square;
            // Reaching the maximum exactly counts as saturation too.
            if (total >= {1'b0, SUM_MAX}) begin
               sum_sq  = SUM_MAX;
               sum_sat = 1'b1;
            end else begin
               sum_sq = total[SUM_BITS-1:0];
            end
         end
         if (px.last_pixel) begin
            result.distance_q8 = root_q8(sum_sq);
            result.saturated   = sum_sat;
            distance_q.push_back(result);
            sum_sq  = '0;
            sum_sat = 1'b0;
         end
      endfunction

      function void check_distance(rsp_type got);
         rsp_type want;
         if (distance_q.size() == 0) begin
            $display("%0t: unexpected result, distance %0d saturated %0d",
                     $time, got.distance_q8, got.saturated);
            errors++;
            return;
         end
         want = distance_q.pop_front();
         if (got.distance_q8 !== want.distance_q8) begin
            $display("%0t: distance_q8 mismatch, expected %0d, actual %0d",
                     $time, want.distance_q8, got.distance_q8);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0d, actual %0d",
                     $time, want.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   req_type                   req_data = '0;
   logic                      rsp_strobe;
   rsp_type                   rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_MASK_ENABLE;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   distance_scoreboard sb = new();
   bit                 steady = 1'b0;
   int unsigned        stall_count = 0;

   masked_patch_l2_distance u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Monitor and watchdog: both look at the values held just before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.add_pixel(req_data);
         if (rsp_strobe) sb.check_distance(rsp_data);
         if ((start && !busy) || rsp_strobe) begin
            stall_count <= 0;
         end else if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end else begin
            stall_count <= stall_count + 1;
         end
      end
   end

   task automatic send_pixel(input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] status, input bit last);
      // Each idle cycle is drawn on its own, with a chance of 23 in 100.
      while (!steady && $urandom_range(0, 99) < 23) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start                 <= 1'b1;
      req_data.pixel_a      <= a;
      req_data.pixel_b      <= b;
      req_data.pixel_status <= status;
      req_data.last_pixel   <= last;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Non-last pixels leave no result behind, so let the pipeline empty too.
   task automatic configure(input bit mask_bit, input logic [7:0] empty_code,
                            input logic [7:0] target_code);
      drain();
      repeat (SETTLE_TICKS) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_MASK_ENABLE;
      csr_wdata <= {7'd0, mask_bit};
      @(posedge clock);
      csr_index <= CSR_EMPTY_CODE;
      csr_wdata <= empty_code;
      @(posedge clock);
      csr_index <= CSR_TARGET_CODE;
      csr_wdata <= target_code;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_codes(mask_bit, empty_code, target_code);
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_status();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return sb.empty_val;
         4, 5, 6: return sb.target_val;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_random(input int count);
      int left;
      left = 0;
      for (int n = 0; n < count; n++) begin
         if (left == 0) begin
            left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(1, 10);
         end
         left--;
         send_pixel(pick_pixel(), pick_pixel(), pick_status(), left == 0);
         if (left == 0 && $urandom_range(0, 39) == 0) drain();
      end
   endtask

   initial begin
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: masking on, empty 0, target 1.
      send_pixel(8'd0, 8'd255, 8'd2, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);           // nothing kept
      send_pixel(8'd255, 8'd255, 8'd1, 1'b0);
      send_pixel(8'd17, 8'd200, 8'd1, 1'b1);        // masked last pixel
      send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
      send_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
      drain();
      send_pixel(8'd100, 8'd37, 8'd128, 1'b1);
      send_pixel(8'd1, 8'd0, 8'd127, 1'b0);
      send_pixel(8'd200, 8'd201, 8'd0, 1'b0);
      send_pixel(8'd9, 8'd9, 8'd64, 1'b1);

      // Masking off: pixels with the empty and target codes count as well.
      configure(1'b0, 8'd0, 8'd1);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd1, 1'b0);
      send_pixel(8'd12, 8'd0, 8'd1, 1'b1);
      run_random(150);

      // Equal empty and target codes.
      configure(1'b1, 8'h5A, 8'h5A);
      send_pixel(8'd10, 8'd250, 8'h5A, 1'b0);
      send_pixel(8'd10, 8'd250, 8'h5B, 1'b0);
      send_pixel(8'd0, 8'd255, 8'h5A, 1'b1);
      run_random(150);

      configure(1'b1, 8'd0, 8'd255);
      steady = 1'b1;
      run_random(150);
      steady = 1'b0;

      configure(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_random(150);

      configure(1'b1, 8'd255, 8'd0);
      run_random(150);

      drain();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/mpl2d_pkg.sv
sv/mpl2d_ctrl.sv
sv/mpl2d_dp.sv
sv/masked_patch_l2_distance.sv
tb/sv/masked_patch_l2_distance_tb.sv
